// ----- rtl/core/swf_pkg.sv -----
// Shared constants and types for the strided window framer.
package swf_pkg;

  localparam int MaxWindow = 64;
  localparam int DataWidth = 32;
  localparam int PtrWidth  = $clog2(MaxWindow);
  localparam int WinWidth  = 7;
  localparam int StrWidth  = 16;
  localparam int PosWidth  = 6;
  localparam int CfgWidth  = 16;
  localparam int OutWidth  = ((DataWidth + PosWidth + 7) / 8) * 8;

  localparam logic [WinWidth-1:0] WinReset = WinWidth'(4);
  localparam logic [StrWidth-1:0] StrReset = StrWidth'(1);

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_STRIDE = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_EOS  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

// ----- rtl/core/swf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module swf_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/strided_window_framer.sv -----
// Strided window framer: cuts a word stream into overlapping or spaced windows.
//
// Input stream (s_axis): one request carries a data word in tdata; tuser is the
// op flag (0 data word, 1 end of stream). End of stream drops a partial window.
// Output stream (m_axis): one request per window word, oldest first; tdata holds
// the word and its position in the window, tlast marks the final word.
// Configuration: cfg_we_i writes register cfg_idx_i (0 window length, 1 stride);
// any write also restarts the stream. Write only while the block is idle.
// Flow: a word that does not complete a window leaves s_axis ready. A word that
// completes a window of W words holds the input while the window is read from
// the ring RAM, one RAM read per cycle while m_axis does not stall; the first
// window word passes the state register, the RAM read register and the output
// register before it appears on m_axis. Back-pressure on m_axis stalls the RAM
// reads through a two-deep output pipeline and so the input. No item is lost or repeated under stalls.
// Reset clears pointers, counts and output valids; the RAM holds no reset
// value and needs no clearing pass, since only words of the current stream
// are read.
module strided_window_framer
  import swf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CfgWidth-1:0]  cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [DataWidth-1:0] s_axis_tdata,   // [31:0] element_value
  input  logic                 s_axis_tuser,   // [0] op
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutWidth-1:0]  m_axis_tdata,   // [31:0] window_word, [37:32] position
  output logic                 m_axis_tlast    // last_of_window
);

  state_e state_q, state_d;

  logic [WinWidth-1:0] win_reg_q;
  logic [StrWidth-1:0] str_reg_q;
  logic [PtrWidth-1:0] wp_q, wp_d;
  logic [WinWidth-1:0] fill_q, fill_d;
  logic [StrWidth-1:0] skip_q, skip_d;
  logic [PtrWidth-1:0] rd_addr_q, rd_addr_d;
  logic [PosWidth-1:0] rd_cnt_q, rd_cnt_d;

  logic [WinWidth-1:0] win_eff;
  logic [StrWidth-1:0] str_eff;
  logic [PosWidth-1:0] win_last;
  logic [WinWidth-1:0] fill_inc;
  logic [WinWidth-1:0] base_full;

  logic in_acc, wr_en, rd_issue, rd_final;
  logic [DataWidth-1:0] rdata;

  logic                pend_v_q;
  logic [PosWidth-1:0] pend_pos_q;
  logic                pend_last_q;
  logic                pend_move;

  logic                 o_v_q;
  logic [DataWidth-1:0] o_word_q;
  logic [PosWidth-1:0]  o_pos_q;
  logic                 o_last_q;

  // effective window 1..MaxWindow, stride at least 1
  always_comb begin
    if (win_reg_q == '0) begin
      win_eff = WinWidth'(1);
    end else if (win_reg_q > WinWidth'(MaxWindow)) begin
      win_eff = WinWidth'(MaxWindow);
    end else begin
      win_eff = win_reg_q;
    end
    str_eff = (str_reg_q == '0) ? StrWidth'(1) : str_reg_q;
  end

  assign win_last  = PosWidth'(win_eff - WinWidth'(1));
  assign fill_inc  = fill_q + WinWidth'(1);
  // oldest slot of the window once the current word is written
  assign base_full = WinWidth'(wp_q) + WinWidth'(1) - win_eff;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = in_acc && (s_axis_tuser == OP_DATA) && (skip_q == '0);

  assign pend_move = pend_v_q && (!o_v_q || m_axis_tready);
  assign rd_issue  = (state_q == ST_EMIT) && (!pend_v_q || pend_move);
  assign rd_final  = rd_issue && (rd_cnt_q == win_last);

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    skip_d    = skip_q;
    rd_addr_d = rd_addr_q;
    rd_cnt_d  = rd_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_EOS) begin
            wp_d   = '0;
            fill_d = '0;
            skip_d = '0;
          end else if (skip_q != '0) begin
            skip_d = skip_q - StrWidth'(1);
          end else begin
            wp_d   = wp_q + PtrWidth'(1);
            fill_d = fill_inc;
            if (fill_inc >= win_eff) begin
              state_d   = ST_EMIT;
              rd_addr_d = base_full[PtrWidth-1:0];
              rd_cnt_d  = '0;
              if (str_eff < StrWidth'(win_eff)) begin
                fill_d = win_eff - WinWidth'(str_eff);
              end else begin
                fill_d = '0;
                skip_d = str_eff - StrWidth'(win_eff);
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (rd_issue) begin
          rd_addr_d = rd_addr_q + PtrWidth'(1);
          rd_cnt_d  = rd_cnt_q + PosWidth'(1);
          if (rd_final) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a register write restarts the stream
    if (cfg_we_i) begin
      wp_d   = '0;
      fill_d = '0;
      skip_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      win_reg_q <= WinReset;
      str_reg_q <= StrReset;
      wp_q      <= '0;
      fill_q    <= '0;
      skip_q    <= '0;
      rd_addr_q <= '0;
      rd_cnt_q  <= '0;
      pend_v_q  <= 1'b0;
      o_v_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      fill_q    <= fill_d;
      skip_q    <= skip_d;
      rd_addr_q <= rd_addr_d;
      rd_cnt_q  <= rd_cnt_d;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_WINDOW: win_reg_q <= cfg_data_i[WinWidth-1:0];
          REG_STRIDE: str_reg_q <= cfg_data_i[StrWidth-1:0];
          default:    win_reg_q <= win_reg_q;
        endcase
      end
      if (rd_issue) begin
        pend_v_q <= 1'b1;
      end else if (pend_move) begin
        pend_v_q <= 1'b0;
      end
      if (pend_move) begin
        o_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_v_q <= 1'b0;
      end
    end
  end

  // payload of the read and output stages
  always_ff @(posedge clk_i) begin
    if (rd_issue) begin
      pend_pos_q  <= rd_cnt_q;
      pend_last_q <= (rd_cnt_q == win_last);
    end
    if (pend_move) begin
      o_word_q <= rdata;
      o_pos_q  <= pend_pos_q;
      o_last_q <= pend_last_q;
    end
  end

  swf_ram #(
    .Width (DataWidth),
    .Depth (MaxWindow)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_issue),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = OutWidth'({o_pos_q, o_word_q});
  assign m_axis_tlast  = o_last_q;

endmodule
